### rtl/core/iwe_pkg.sv
package iwe_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIG_DICTIONARY = 2'd0;
    localparam logic [1:0] CFG_LITERALS_ON    = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_LENGTH  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DIST_W      = 13;
    localparam int LEN_W       = 9;
    localparam int POS_W       = 32;
    localparam int WORD_LANES  = 8;
    localparam int WORD_W      = 64;
    localparam int COUNT_W     = 4;

    localparam int NUM_LOW_BITS_BIG   = 7;
    localparam int NUM_LOW_BITS_SMALL = 6;

    localparam logic [5:0] LEN_ESCAPE_SYMBOL = 6'd63;
    localparam logic [LEN_W-1:0] MIN_LEN_LITERALS_ON  = 9'd3;
    localparam logic [LEN_W-1:0] MIN_LEN_LITERALS_OFF = 9'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
    } cmd_t;

    typedef struct packed {
        logic issue_ok;
        logic final_byte;
        logic drained;
    } status_t;

endpackage

### rtl/core/iwe_ctrl.sv
module iwe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  iwe_pkg::status_t  sts,
    output iwe_pkg::cmd_t     cmd
);

    iwe_pkg::state_t state_reg;
    iwe_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        tok_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.issue  = 1'b0;
        unique case (state_reg)
            iwe_pkg::ST_IDLE:
            begin
                tok_ready = 1'b1;
                if (tok_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = iwe_pkg::ST_ISSUE;
                end
            end
            iwe_pkg::ST_ISSUE:
            begin
                cmd.issue = sts.issue_ok;
                if (sts.issue_ok && sts.final_byte)
                begin
                    state_next = iwe_pkg::ST_FLUSH;
                end
            end
            iwe_pkg::ST_FLUSH:
            begin
                if (sts.drained)
                begin
                    state_next = iwe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iwe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iwe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/iwe_datapath.sv
module iwe_datapath #(
    parameter int WINDOW_BYTES     = 8192,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [iwe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [iwe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              is_match,
    input  logic [7:0]                        literal_byte,
    input  logic [5:0]                        distance_symbol,
    input  logic [6:0]                        low_distance_bits,
    input  logic [5:0]                        length_symbol,
    input  logic [7:0]                        extra_length,
    output logic                              word_valid,
    input  logic                              word_ready,
    output logic [iwe_pkg::WORD_W-1:0]        out_bytes,
    output logic [iwe_pkg::COUNT_W-1:0]       byte_count,
    output logic                              last_of_item,
    output logic                              stream_done,
    output logic                              overrun,
    input  iwe_pkg::cmd_t                     cmd,
    output iwe_pkg::status_t                  sts
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW:0]   WIN_SIZE = (AW+1)'(WINDOW_BYTES);
    localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_BYTES - 1);
    localparam logic [iwe_pkg::COUNT_W-1:0] WORD_BYTES = iwe_pkg::COUNT_W'(BYTES_PER_RESULT);
    localparam logic [iwe_pkg::POS_W-1:0] POS_MAX = '1;

    // Configuration
    logic                        big_dict_reg;
    logic                        lit_on_reg;
    logic [iwe_pkg::POS_W-1:0]   out_len_reg;

    // Current token
    logic                        match_reg;
    logic [7:0]                  lit_reg;
    logic [iwe_pkg::DIST_W-1:0]  dist_reg;
    logic [iwe_pkg::LEN_W-1:0]   remain_reg;
    logic [AW-1:0]               rd_ptr_reg;

    // Window and position
    logic [7:0]                  window_mem [WINDOW_BYTES];
    logic [AW-1:0]               wr_ptr_reg;
    logic [iwe_pkg::POS_W-1:0]   pos_reg;
    logic [7:0]                  rdata_reg;
    logic [7:0]                  last_byte_reg;

    // Write stage
    logic                        s2_valid_reg;
    logic                        s2_last_reg;

    // Word packing and output
    logic [iwe_pkg::WORD_W-1:0]  word_reg;
    logic [iwe_pkg::COUNT_W-1:0] cnt_reg;
    logic                        out_valid_reg;
    logic [iwe_pkg::WORD_W-1:0]  out_bytes_reg;
    logic [iwe_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_last_reg;
    logic                        out_done_reg;
    logic                        out_overrun_reg;

    logic [iwe_pkg::DIST_W-1:0]  tok_dist;
    logic [iwe_pkg::LEN_W-1:0]   tok_len;
    logic [AW:0]                 back;
    logic [AW-1:0]               start_ptr;
    logic                        can_emit;
    logic                        word_done;
    logic                        s2_adv;
    logic                        src_before_start;
    logic [7:0]                  s2_byte;
    logic [iwe_pkg::WORD_W-1:0]  word_ins;
    logic [iwe_pkg::POS_W-1:0]   pos_inc;

    // Distance and length of the offered token
    always_comb
    begin
        if (big_dict_reg)
        begin
            tok_dist = {distance_symbol, low_distance_bits};
        end
        else
        begin
            tok_dist = {1'b0, distance_symbol, low_distance_bits[5:0]};
        end
        tok_len = iwe_pkg::LEN_W'(length_symbol)
                + (lit_on_reg ? iwe_pkg::MIN_LEN_LITERALS_ON : iwe_pkg::MIN_LEN_LITERALS_OFF);
        if (length_symbol == iwe_pkg::LEN_ESCAPE_SYMBOL)
        begin
            tok_len = tok_len + iwe_pkg::LEN_W'(extra_length);
        end
        back = (AW+1)'(tok_dist) + (AW+1)'(1);
        if ({1'b0, wr_ptr_reg} >= back)
        begin
            start_ptr = AW'({1'b0, wr_ptr_reg} - back);
        end
        else
        begin
            start_ptr = AW'({1'b0, wr_ptr_reg} + WIN_SIZE - back);
        end
    end

    // Byte in the write stage
    always_comb
    begin
        can_emit  = !out_valid_reg || word_ready;
        word_done = s2_last_reg || (cnt_reg + 4'd1 == WORD_BYTES);
        s2_adv    = s2_valid_reg && (!word_done || can_emit);
        src_before_start = {{(iwe_pkg::POS_W-iwe_pkg::DIST_W){1'b0}}, dist_reg} >= pos_reg;
        if (!match_reg)
        begin
            s2_byte = lit_reg;
        end
        else if (src_before_start)
        begin
            s2_byte = 8'd0;
        end
        else if (dist_reg == '0)
        begin
            // The source is the most recently written byte.
            s2_byte = last_byte_reg;
        end
        else
        begin
            s2_byte = rdata_reg;
        end
        for (int lane = 0; lane < iwe_pkg::WORD_LANES; lane++)
        begin
            word_ins[lane*8 +: 8] = (cnt_reg == iwe_pkg::COUNT_W'(lane))
                                  ? s2_byte : word_reg[lane*8 +: 8];
        end
        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 32'd1;
    end

    always_comb
    begin
        sts.issue_ok   = !s2_valid_reg || s2_adv;
        sts.final_byte = remain_reg == iwe_pkg::LEN_W'(1);
        sts.drained    = !s2_valid_reg || s2_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_dict_reg <= 1'b0;
            lit_on_reg   <= 1'b0;
            out_len_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                iwe_pkg::CFG_BIG_DICTIONARY: big_dict_reg <= cfg_data[0];
                iwe_pkg::CFG_LITERALS_ON:    lit_on_reg   <= cfg_data[0];
                iwe_pkg::CFG_OUTPUT_LENGTH:  out_len_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            match_reg <= is_match;
            lit_reg   <= literal_byte;
            dist_reg  <= tok_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (cmd.load)
        begin
            remain_reg <= is_match ? tok_len : iwe_pkg::LEN_W'(1);
            rd_ptr_reg <= start_ptr;
        end
        else if (cmd.issue)
        begin
            remain_reg <= remain_reg - iwe_pkg::LEN_W'(1);
            rd_ptr_reg <= (rd_ptr_reg == WIN_LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rdata_reg <= window_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            window_mem[wr_ptr_reg] <= s2_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            wr_ptr_reg    <= '0;
            pos_reg       <= '0;
            last_byte_reg <= '0;
            word_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                s2_valid_reg <= 1'b1;
                s2_last_reg  <= remain_reg == iwe_pkg::LEN_W'(1);
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                wr_ptr_reg    <= (wr_ptr_reg == WIN_LAST) ? '0 : wr_ptr_reg + AW'(1);
                pos_reg       <= pos_inc;
                last_byte_reg <= s2_byte;
                if (word_done)
                begin
                    word_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    word_reg <= word_ins;
                    cnt_reg  <= cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv && word_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (word_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && word_done)
        begin
            out_bytes_reg   <= word_ins;
            out_count_reg   <= cnt_reg + 4'd1;
            out_last_reg    <= s2_last_reg;
            out_done_reg    <= pos_inc >= out_len_reg;
            out_overrun_reg <= pos_inc > out_len_reg;
        end
    end

    assign word_valid   = out_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign byte_count   = out_count_reg;
    assign last_of_item = out_last_reg;
    assign stream_done  = out_done_reg;
    assign overrun      = out_overrun_reg;

endmodule

### rtl/core/implode_window_expander.sv
// Implode window expander: takes decoded implode tokens (a literal byte, or a match
// given as distance symbol, low distance bits, length symbol and extra length bits)
// and rebuilds the byte stream through a WINDOW_BYTES history window, handing it
// out in words of up to BYTES_PER_RESULT bytes with the first byte in bits 7..0.
// Match bytes whose source lies before the start of the stream come out as zero.
// The window is read and written at most once per cycle; a write stalls when it
// ends a word while the previous word waits to be taken. A word may wait in the
// output register while the next transaction is taken. The user must write
// configuration only while no token is in progress; the block does not enforce
// this. A token is taken only once the previous one is written; stream_done and
// overrun compare the saturating byte position with output_length after each word.
module implode_window_expander #(
    parameter int WINDOW_BYTES     = 8192,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [iwe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [iwe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              tok_valid,
    output logic                              tok_ready,
    input  logic                              is_match,
    input  logic [7:0]                        literal_byte,
    input  logic [5:0]                        distance_symbol,
    input  logic [6:0]                        low_distance_bits,
    input  logic [5:0]                        length_symbol,
    input  logic [7:0]                        extra_length,
    output logic                              word_valid,
    input  logic                              word_ready,
    output logic [iwe_pkg::WORD_W-1:0]        out_bytes,
    output logic [iwe_pkg::COUNT_W-1:0]       byte_count,
    output logic                              last_of_item,
    output logic                              stream_done,
    output logic                              overrun
);

    iwe_pkg::cmd_t    cmd;
    iwe_pkg::status_t sts;

    iwe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    iwe_datapath #(
        .WINDOW_BYTES     (WINDOW_BYTES),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .is_match          (is_match),
        .literal_byte      (literal_byte),
        .distance_symbol   (distance_symbol),
        .low_distance_bits (low_distance_bits),
        .length_symbol     (length_symbol),
        .extra_length      (extra_length),
        .word_valid        (word_valid),
        .word_ready        (word_ready),
        .out_bytes         (out_bytes),
        .byte_count        (byte_count),
        .last_of_item      (last_of_item),
        .stream_done       (stream_done),
        .overrun           (overrun),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule
